[rtl/looped_motion_recorder_player_macros.svh]
// Assertion macros for the looped motion recorder and player.
// Used by the top level only; no other dependencies.
`ifndef LOOPED_MOTION_RECORDER_PLAYER_MACROS_SVH
`define LOOPED_MOTION_RECORDER_PLAYER_MACROS_SVH
// check that an antecedent implies a consequent on the next edge
`define LMRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("label failed");
// check that a condition holds at every edge outside reset
`define LMRP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("label failed");
`endif

[rtl/lmrp_pkg.sv]
// Package for the looped motion recorder and player: types, constants, operation codes.
// No dependencies.
`timescale 1ns / 1ps
package lmrp_pkg;
  localparam int SampleDepth = 1024;
  localparam int AddrBits = $clog2(SampleDepth);
  localparam int CountBits = AddrBits + 1;
  localparam int TimeBits = 32;
  localparam logic [15:0] XMin = 16'd1311;
  localparam logic [15:0] XMax = 16'd64225;
  localparam logic [15:0] YMin = 16'd3277;
  localparam logic [15:0] YMax = 16'd62259;
  localparam logic [15:0] SpeedOne = 16'd256;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_SET_POS = 3'd1, OP_START_REC = 3'd2, OP_STOP_REC = 3'd3,
    OP_PAUSE = 3'd4, OP_RESUME = 3'd5, OP_CLEAR = 3'd6, OP_SET_SPEED = 3'd7
  } op_t;

  typedef enum logic [0:0] {
    CFG_ENABLED = 1'b0, CFG_COEFF = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_MUL_WAIT, ST_MOD_WAIT, ST_SEARCH, ST_SEARCH_WAIT,
    ST_NEXT_WAIT, ST_FRAC_WAIT, ST_LERP, ST_SMOOTH, ST_RESUME_WAIT, ST_DONE
  } state_t;

  // request and reply of the shared long divider
  typedef struct packed {
    logic        go;
    logic [55:0] num;
    logic [39:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [55:0] quot;
    logic [39:0] rem;
  } div_rsp_t;

  // one sample store entry: time, x, y
  typedef struct packed {
    logic [TimeBits-1:0] t;
    logic [15:0] x;
    logic [15:0] y;
  } sample_t;
endpackage

[rtl/lmrp_divider.sv]
// Restoring divider, one quotient bit per cycle, 56-bit numerator by 40-bit divisor.
// Depends on lmrp_pkg.
`timescale 1ns / 1ps
module lmrp_divider
  import lmrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [55:0] quot;
  logic [40:0] rem;
  logic [39:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [40:0] trial;
  logic [40:0] shifted;

  // form the next partial remainder
  always_comb begin
    shifted = {rem[39:0], quot[55]};
    trial = shifted - {1'b0, den};
  end

  // iterate over the numerator bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_r <= 1'b0;
      cnt <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        quot <= req.num;
        den <= req.den;
        rem <= '0;
        cnt <= 6'd56;
      end else if (busy) begin
        if (!trial[40]) begin
          rem <= trial;
          quot <= {quot[54:0], 1'b1};
        end else begin
          rem <= shifted;
          quot <= {quot[54:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, quot: quot, rem: rem[39:0]};
endmodule

[rtl/looped_motion_recorder_player.sv]
// Looped motion recorder and player (top level).
// Depends on lmrp_pkg, lmrp_divider and looped_motion_recorder_player_macros.svh.
//
// Usage: raise start with an operation and its fields while busy is low; the
// transaction is taken at that edge and busy rises. The one result comes out
// on the result ports with done high for a single cycle, and busy falls
// together with it. The receiver cannot stall; it must take the result then.
// Configuration writes (index 0 enabled, 1 smoothing_coeff) use cfg_valid /
// cfg_ready and are taken whenever the block is idle; cfg_ready is low while
// an operation runs.
// A playing tick runs one divide for the loop time, a linear walk through the
// sample store at one sample per cycle (one read port, registered read), and a
// second divide for the fraction. Resume takes one divide; the other
// operations and the ticks that do not play need no divide.
// One operation runs at a time; the next is taken from the cycle done is high.
// Reset clears the control and architectural state at once; the sample store has
// no clearing pass since only entries below the sample count are used.
`timescale 1ns / 1ps
module looped_motion_recorder_player
  import lmrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] time_now,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  input  logic [15:0] new_speed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] volume,
  output logic signed [15:0] pan,
  output logic        is_recording,
  output logic        has_loop,
  output logic        is_paused,
  output logic [10:0] samples_stored,
  output logic        store_full
);
`include "looped_motion_recorder_player_macros.svh"

  // architectural state
  logic        enabled;
  logic [15:0] coeff;
  logic [CountBits-1:0] count;
  logic [TimeBits-1:0]  rec_start, loop_dur, play_start;
  logic [39:0] paused_el;
  logic [15:0] speed;
  logic        f_rec, f_loop, f_pause, f_drop;
  logic [15:0] px, py;
  logic [15:0] sm_vol;
  logic signed [15:0] sm_pan;

  // operation registers
  state_t state, state_next;
  op_t    op;
  logic [TimeBits-1:0] now;
  logic [15:0] nx, ny, nspd;
  logic [47:0] prod;
  logic [39:0] lt;
  logic [AddrBits-1:0] idx;
  sample_t s1, s2;
  logic [16:0] frac;
  logic [1:0]  smooth_ph;

  // sample store, one read and one write port
  sample_t mem [SampleDepth];
  sample_t rd_data;
  logic [AddrBits-1:0] rd_addr;
  logic    wr_en;
  sample_t wr_data;
  logic [AddrBits-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  div_req_t dreq;
  div_rsp_t drsp;
  lmrp_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  logic playing;
  assign playing = enabled && f_loop && !f_rec && !f_pause && count > 1 && loop_dur != '0;

  // compare and step helpers
  logic [TimeBits-1:0] diff;
  assign diff = now - play_start;
  logic last_idx;
  assign last_idx = ({1'b0, idx} + 1'b1) >= count;

  // lerp on each axis: scale the span by the fraction
  logic [15:0] dx, dy;
  logic [32:0] mx, my;
  always_comb begin
    dx = (s2.x >= s1.x) ? s2.x - s1.x : s1.x - s2.x;
    dy = (s2.y >= s1.y) ? s2.y - s1.y : s1.y - s2.y;
    mx = frac * dx;
    my = frac * dy;
  end

  // smoothing: one multiply per phase
  logic signed [17:0] vol_t, pan_t, d_s;
  logic [16:0] mag;
  logic [32:0] stp;
  logic signed [17:0] cur_s;
  always_comb begin
    vol_t = 18'sd65536 - $signed({2'b00, py});
    if (vol_t > 18'sd65535) vol_t = 18'sd65535;
    pan_t = $signed({2'b00, px}) - 18'sd32768;
    cur_s = (smooth_ph == 2'd0) ? $signed({2'b00, sm_vol}) : 18'(sm_pan);
    d_s = ((smooth_ph == 2'd0) ? vol_t : pan_t) - cur_s;
    mag = d_s[17] ? 17'(-d_s) : d_s[16:0];
    stp = mag * coeff;
  end
  logic signed [17:0] smooth_res;
  assign smooth_res = d_s[17] ? cur_s - $signed({1'b0, stp[32:16]})
                              : cur_s + $signed({1'b0, stp[32:16]});

  // fraction setup: segment end time, last segment ends at the loop length
  logic [TimeBits-1:0] t2v;
  logic frac_phase;
  always_comb begin
    t2v = (last_idx) ? loop_dur : rd_data.t;
  end

  logic [TimeBits-1:0] t2_r;
  always_ff @(posedge clk) begin
    if (state == ST_NEXT_WAIT) t2_r <= t2v;
  end

  // fraction division request, issued once on entry if the segment times allow it
  logic frac_go;
  logic frac_ok;
  assign frac_ok = (t2_r > s1.t) && (lt > {8'd0, s1.t});
  assign frac_go = (state == ST_FRAC_WAIT) && !frac_phase && frac_ok;

  div_req_t dreq_frac;
  always_comb begin
    dreq_frac.go = frac_go;
    dreq_frac.num = {lt - {8'd0, s1.t}, 16'd0};
    dreq_frac.den = {8'd0, t2_r - s1.t};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (accept) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (op == OP_TICK && enabled) state_next = playing ? ST_MUL_WAIT : ST_SMOOTH;
        else if (op == OP_RESUME && f_loop && f_pause && speed != '0)
          state_next = ST_RESUME_WAIT;
        else state_next = ST_DONE;
      end
      ST_MUL_WAIT:    state_next = ST_MOD_WAIT;
      ST_MOD_WAIT:    if (drsp.done) state_next = ST_SEARCH;
      ST_SEARCH:      state_next = ST_SEARCH_WAIT;
      ST_SEARCH_WAIT: state_next = ST_NEXT_WAIT;
      ST_NEXT_WAIT: begin
        if (last_idx || {8'd0, rd_data.t} > lt) state_next = ST_FRAC_WAIT;
        else state_next = ST_NEXT_WAIT;
      end
      ST_FRAC_WAIT:
        if ((!frac_phase && !frac_ok) || drsp.done) state_next = ST_LERP;
      ST_LERP:        state_next = ST_SMOOTH;
      ST_SMOOTH:      if (smooth_ph == 2'd1) state_next = ST_DONE;
      ST_RESUME_WAIT: if (drsp.done) state_next = ST_DONE;
      ST_DONE:        state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  // outputs and control strobes
  always_comb begin
    dreq = '0;
    rd_addr = idx;
    wr_en = 1'b0;
    wr_addr = count[AddrBits-1:0];
    wr_data = '{t: now - rec_start, x: px, y: py};
    unique case (state)
      ST_MUL_WAIT: begin
        dreq.go = 1'b1;
        dreq.num = {16'd0, prod[47:8]};
        dreq.den = {8'd0, loop_dur};
      end
      ST_RESUME_WAIT: begin
        dreq.go = !frac_phase;
        dreq.num = {paused_el, 16'd0} >> 8;
        dreq.den = {24'd0, speed};
      end
      ST_FRAC_WAIT: dreq = dreq_frac;
      ST_SEARCH: rd_addr = '0;
      ST_SEARCH_WAIT: rd_addr = idx + 1'b1;
      ST_NEXT_WAIT: rd_addr = idx + 2'd2;
      ST_SMOOTH: wr_en = (smooth_ph == 2'd0) && f_rec && (count < CountBits'(SampleDepth));
      default: ;
    endcase
  end

  // second endpoint: the wrap segment returns to sample zero
  sample_t s_first;
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH_WAIT) s_first <= rd_data;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      enabled <= 1'b1;
      coeff <= 16'd6554;
      count <= '0;
      rec_start <= '0;
      loop_dur <= '0;
      play_start <= '0;
      paused_el <= '0;
      speed <= SpeedOne;
      f_rec <= 1'b0; f_loop <= 1'b0; f_pause <= 1'b0; f_drop <= 1'b0;
      px <= 16'd32768; py <= 16'd32768;
      sm_vol <= '0; sm_pan <= '0;
      done <= 1'b0;
      smooth_ph <= '0;
      frac_phase <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_ENABLED) enabled <= cfg_data[0];
        else coeff <= cfg_data;
      end
      unique case (state)
        ST_IDLE: if (accept) begin
          op <= op_t'(operation);
          now <= time_now;
          nx <= new_x; ny <= new_y; nspd <= new_speed;
          smooth_ph <= '0;
          frac_phase <= 1'b0;
        end
        ST_DISPATCH: begin
          prod <= diff * speed;
          unique case (op)
            OP_SET_POS: begin
              px <= (nx < XMin) ? XMin : ((nx > XMax) ? XMax : nx);
              py <= (ny < YMin) ? YMin : ((ny > YMax) ? YMax : ny);
            end
            OP_START_REC: begin
              count <= '0; rec_start <= now;
              f_rec <= 1'b1; f_loop <= 1'b0; f_drop <= 1'b0;
            end
            OP_STOP_REC: if (f_rec) begin
              f_rec <= 1'b0;
              if (count > 1) begin
                loop_dur <= now - rec_start; play_start <= now; f_loop <= 1'b1;
                speed <= SpeedOne; f_pause <= 1'b0; paused_el <= '0;
              end
            end
            OP_PAUSE: begin
              // scaled time is needed, so compute it here in two steps
            end
            OP_RESUME: if (f_loop && f_pause && speed == '0) begin
              play_start <= now; f_pause <= 1'b0;
            end
            OP_CLEAR: begin
              f_loop <= 1'b0; f_rec <= 1'b0; f_pause <= 1'b0; f_drop <= 1'b0;
              count <= '0; loop_dur <= '0; play_start <= '0;
              speed <= SpeedOne; paused_el <= '0;
            end
            OP_SET_SPEED: speed <= nspd;
            default: ;
          endcase
        end
        ST_MOD_WAIT: if (drsp.done) lt <= drsp.rem;
        ST_SEARCH: idx <= '0;
        ST_SEARCH_WAIT: s1 <= rd_data;
        ST_NEXT_WAIT: begin
          if (last_idx || {8'd0, rd_data.t} > lt) begin
            if (last_idx) s2 <= s_first;
            else s2 <= rd_data;
            frac_phase <= 1'b0;
          end else begin
            idx <= idx + 1'b1;
            s1 <= rd_data;
          end
        end
        ST_FRAC_WAIT: begin
          if (!frac_phase) begin
            frac_phase <= 1'b1;
            frac <= '0;
          end else if (drsp.done) begin
            frac <= (drsp.quot > 56'd65536) ? 17'd65536 : drsp.quot[16:0];
          end
        end
        ST_LERP: begin
          px <= (s2.x >= s1.x) ? s1.x + mx[31:16] : s1.x - mx[31:16];
          py <= (s2.y >= s1.y) ? s1.y + my[31:16] : s1.y - my[31:16];
        end
        ST_SMOOTH: begin
          smooth_ph <= smooth_ph + 2'd1;
          if (smooth_ph == 2'd0) begin
            sm_vol <= smooth_res[15:0];
            if (f_rec) begin
              if (count < CountBits'(SampleDepth)) count <= count + 1'b1;
              else f_drop <= 1'b1;
            end
          end else begin
            sm_pan <= smooth_res[15:0];
          end
        end
        ST_RESUME_WAIT: begin
          frac_phase <= 1'b1;
          if (drsp.done) begin
            play_start <= now - drsp.quot[TimeBits-1:0];
            f_pause <= 1'b0;
          end
        end
        default: ;
      endcase
      // pause captures scaled time in the cycle after dispatch
      if (state == ST_DONE && op == OP_PAUSE && f_loop && !f_pause) begin
        paused_el <= prod[47:8];
        f_pause <= 1'b1;
      end
    end
  end

  // result ports
  assign pos_x = px;
  assign pos_y = py;
  assign volume = sm_vol;
  assign pan = sm_pan;
  assign is_recording = f_rec;
  assign has_loop = f_loop;
  assign is_paused = f_pause;
  assign samples_stored = count;
  assign store_full = f_drop;

  `LMRP_ASSERT_ALWAYS(a_done_when_idle, !(done && busy))
  `LMRP_ASSERT_ALWAYS(a_count_bound, count <= CountBits'(SampleDepth))
  `LMRP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule

[test/looped_motion_recorder_player_checker.sv]
// Checker for the looped motion recorder and player: watches the command,
// configuration and result channels, predicts each result and compares it.
// Depends on lmrp_pkg.
`timescale 1ns / 1ps
module looped_motion_recorder_player_checker
  import lmrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  operation,
  input  logic [31:0] time_now,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  input  logic [15:0] new_speed,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        done,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] volume,
  input  logic signed [15:0] pan,
  input  logic        is_recording,
  input  logic        has_loop,
  input  logic        is_paused,
  input  logic [10:0] samples_stored,
  input  logic        store_full,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] vol;
    logic [15:0] pn;
    logic        rec;
    logic        lp;
    logic        pause;
    logic [10:0] cnt;
    logic        full;
  } motion_state_t;

  // predicted block state
  logic [31:0] trail_t [SampleDepth];
  logic [15:0] trail_x [SampleDepth];
  logic [15:0] trail_y [SampleDepth];
  int unsigned trail_len;
  logic [31:0] rec_origin, loop_len, play_origin;
  logic [39:0] frozen_elapsed;
  logic [15:0] play_speed, cur_x, cur_y, smooth_coeff;
  logic        recording, looping, paused, dropped, active;
  int          level_vol, level_pan;

  motion_state_t expected_motion[$];

  assign pending = expected_motion.size();

  function automatic longint unsigned scaled_time(logic [31:0] now);
    logic [31:0] diff;
    diff = now - play_origin;
    return (longint'(diff) * longint'(play_speed)) >> 8;
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b,
                                        longint unsigned f);
    longint unsigned span;
    if (b >= a) begin
      span = b - a;
      return a + 16'((span * f) >> 16);
    end
    span = a - b;
    return a - 16'((span * f) >> 16);
  endfunction

  function automatic int ease(int cur, int target);
    longint d;
    longint unsigned mag;
    longint stp;
    d = longint'(target) - longint'(cur);
    mag = d < 0 ? -d : d;
    stp = longint'((mag * smooth_coeff) >> 16);
    return d < 0 ? int'(cur - stp) : int'(cur + stp);
  endfunction

  // interpolate the position along the recorded loop
  task automatic follow_loop(logic [31:0] now);
    longint unsigned lt, t1, t2, f;
    int unsigned i, idx, nxt;
    f = 0;
    idx = 0;
    if (!looping || trail_len < 2 || loop_len == 0) return;
    lt = scaled_time(now) % loop_len;
    for (i = 0; i < trail_len; i++) begin
      idx = i;
      if (i + 1 >= trail_len || trail_t[i + 1] > lt) break;
    end
    nxt = (idx + 1 >= trail_len) ? 0 : idx + 1;
    t1 = trail_t[idx];
    t2 = (nxt == 0) ? loop_len : trail_t[nxt];
    if (t2 > t1 && lt > t1) begin
      f = ((lt - t1) << 16) / (t2 - t1);
      if (f > 65536) f = 65536;
    end
    cur_x = blend(trail_x[idx], trail_x[nxt], f);
    cur_y = blend(trail_y[idx], trail_y[nxt], f);
  endtask

  task automatic wipe();
    looping = 0;
    recording = 0;
    paused = 0;
    dropped = 0;
    trail_len = 0;
    loop_len = 0;
    play_origin = 0;
    play_speed = SpeedOne;
    frozen_elapsed = 0;
  endtask

  // apply one operation and queue the state it leaves
  task automatic apply_op(op_t op, logic [31:0] now, logic [15:0] nx, logic [15:0] ny,
                          logic [15:0] ns);
    motion_state_t r;
    int vt;
    longint unsigned back;
    case (op)
      OP_TICK: begin
        if (active) begin
          if (looping && !recording && !paused) follow_loop(now);
          if (recording) begin
            if (trail_len < SampleDepth) begin
              trail_t[trail_len] = now - rec_origin;
              trail_x[trail_len] = cur_x;
              trail_y[trail_len] = cur_y;
              trail_len++;
            end else begin
              dropped = 1;
            end
          end
          vt = 65536 - int'(cur_y);
          if (vt > 65535) vt = 65535;
          level_vol = ease(level_vol, vt);
          level_pan = ease(level_pan, int'(cur_x) - 32768);
        end
      end
      OP_SET_POS: begin
        cur_x = nx < XMin ? XMin : (nx > XMax ? XMax : nx);
        cur_y = ny < YMin ? YMin : (ny > YMax ? YMax : ny);
      end
      OP_START_REC: begin
        trail_len = 0;
        rec_origin = now;
        recording = 1;
        looping = 0;
        dropped = 0;
      end
      OP_STOP_REC: begin
        if (recording) begin
          recording = 0;
          if (trail_len > 1) begin
            loop_len = now - rec_origin;
            play_origin = now;
            looping = 1;
            play_speed = SpeedOne;
            paused = 0;
            frozen_elapsed = 0;
          end
        end
      end
      OP_PAUSE: begin
        if (looping && !paused) begin
          frozen_elapsed = 40'(scaled_time(now));
          paused = 1;
        end
      end
      OP_RESUME: begin
        if (looping && paused) begin
          back = (play_speed == 0) ? 0 : (longint'(frozen_elapsed) << 8) / play_speed;
          play_origin = now - 32'(back);
          paused = 0;
        end
      end
      OP_CLEAR: wipe();
      default: play_speed = ns;
    endcase
    r.px = cur_x;
    r.py = cur_y;
    r.vol = 16'(level_vol);
    r.pn = 16'(level_pan);
    r.rec = recording;
    r.lp = looping;
    r.pause = paused;
    r.cnt = 11'(trail_len);
    r.full = dropped;
    expected_motion.insert(expected_motion.size(), r);
  endtask

  // compare results first, then take new transactions
  always @(posedge clk) begin
    motion_state_t got, want;
    if (rst) begin
      wipe();
      rec_origin = 0;
      cur_x = 16'd32768;
      cur_y = 16'd32768;
      level_vol = 0;
      level_pan = 0;
      active = 1;
      smooth_coeff = 16'd6554;
      expected_motion.delete();
      errors = 0;
    end else begin
      if (done) begin
        got = '{pos_x, pos_y, volume, pan, is_recording, has_loop, is_paused,
                samples_stored, store_full};
        if (expected_motion.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with nothing expected", $realtime);
        end else begin
          want = expected_motion.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch exp x=%h y=%h vol=%h pan=%h rec=%b loop=%b ",
                        "pause=%b cnt=%0d full=%b / got x=%h y=%h vol=%h pan=%h rec=%b ",
                        "loop=%b pause=%b cnt=%0d full=%b"}, $realtime,
                       want.px, want.py, want.vol, want.pn, want.rec, want.lp,
                       want.pause, want.cnt, want.full, got.px, got.py, got.vol,
                       got.pn, got.rec, got.lp, got.pause, got.cnt, got.full);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_idx_t'(cfg_index) == CFG_ENABLED) active = cfg_data[0];
        else smooth_coeff = cfg_data;
      end
      if (start && !busy)
        apply_op(op_t'(operation), time_now, new_x, new_y, new_speed);
    end
  end

endmodule

[test/looped_motion_recorder_player_tb.sv]
// Testbench top for the looped motion recorder and player: drives directed and
// random operations and configuration writes, and reports the verdict.
// Depends on lmrp_pkg, looped_motion_recorder_player and its checker.
`timescale 1ns / 1ps
module looped_motion_recorder_player_tb;
  import lmrp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic [2:0]  operation = '0;
  logic [31:0] time_now = '0;
  logic [15:0] new_x = '0, new_y = '0, new_speed = '0;
  logic        cfg_valid = 0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        busy, cfg_ready, done;
  logic [15:0] pos_x, pos_y, volume;
  logic signed [15:0] pan;
  logic        is_recording, has_loop, is_paused, store_full;
  logic [10:0] samples_stored;
  int          errors, pending;
  logic [31:0] clock_ms;
  int          sent;
  bit          no_gaps;

  always #10 clk = ~clk;

  looped_motion_recorder_player uut (.*);
  looped_motion_recorder_player_checker chk (.*);

  // hold start high until the transaction is taken
  task automatic send(op_t op, logic [15:0] nx = '0, logic [15:0] ny = '0,
                      logic [15:0] ns = '0);
    int gap;
    bit ok;
    gap = no_gaps ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(3, 40));
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    operation <= op;
    time_now <= clock_ms;
    new_x <= nx;
    new_y <= ny;
    new_speed <= ns;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    sent++;
  endtask

  // advance time, mostly a little, now and then far
  task automatic advance(int unsigned most);
    if ($urandom_range(0, 60) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, most);
  endtask

  // drop start and wait for every result
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    bit ok;
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic tick();
    advance(40);
    send(OP_TICK);
  endtask

  task automatic random_op();
    op_t op;
    op = op_t'($urandom_range(0, 7));
    advance(300);
    send(op, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // record a short path with random content, then play with it
  task automatic recorded_path();
    int n, m;
    advance(100);
    send(OP_START_REC);
    n = $urandom_range(1, 30);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) send(OP_SET_POS, 16'($urandom), 16'($urandom));
      tick();
    end
    advance(60);
    send(OP_STOP_REC);
    m = $urandom_range(3, 14);
    repeat (m) begin
      case ($urandom_range(0, 9))
        0: begin advance(200); send(OP_PAUSE); end
        1: begin advance(200); send(OP_RESUME); end
        2: send(OP_SET_SPEED, '0, '0,
                $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(64, 1024)));
        3: send(OP_SET_POS, 16'($urandom), 16'($urandom));
        default: begin advance(400); send(OP_TICK); end
      endcase
    end
  endtask

  initial begin
    #200_000_000;
    $display("looped_motion_recorder_player_tb NOT OK");
    $finish;
  end

  initial begin
    sent = 0;
    no_gaps = 0;
    clock_ms = 32'd1000;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, ignored requests, short and zero-length recordings
    send(OP_SET_POS, 16'h0000, 16'h0000);
    tick();
    send(OP_SET_POS, 16'hFFFF, 16'hFFFF);
    tick();
    send(OP_STOP_REC);
    send(OP_PAUSE);
    send(OP_RESUME);
    send(OP_START_REC);
    tick();
    send(OP_STOP_REC);
    send(OP_START_REC);
    send(OP_TICK);
    send(OP_TICK);
    send(OP_STOP_REC);
    tick();
    send(OP_CLEAR);
    send(OP_START_REC);
    tick();
    send(OP_SET_POS, 16'd1311, 16'd62259);
    tick();
    clock_ms = 32'hFFFF_FFF0;
    tick();
    send(OP_STOP_REC);
    tick();
    send(OP_SET_SPEED, '0, '0, 16'hFFFF);
    tick();
    send(OP_PAUSE);
    send(OP_PAUSE);
    send(OP_SET_SPEED, '0, '0, 16'h0000);
    tick();
    send(OP_RESUME);
    send(OP_RESUME);

    // configuration extremes between phases
    write_reg(CFG_COEFF, 16'd1);
    tick();
    write_reg(CFG_COEFF, 16'hFFFF);
    tick();
    write_reg(CFG_ENABLED, 16'h0000);
    send(OP_START_REC);
    tick();
    tick();
    send(OP_STOP_REC);
    write_reg(CFG_ENABLED, 16'hFFFF);

    // fill the store past its depth, then play the full loop
    no_gaps = 1;
    send(OP_START_REC);
    repeat (SampleDepth + 4) begin
      clock_ms = clock_ms + 1;
      send(OP_TICK);
    end
    send(OP_STOP_REC);
    repeat (3) begin advance(2000); send(OP_TICK); end
    send(OP_CLEAR);
    no_gaps = 0;
    sent = 0;

    // random part: mostly recorded paths, some noise
    while (sent < 500) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) recorded_path();
      else repeat ($urandom_range(1, 8)) random_op();
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) write_reg(CFG_ENABLED, 16'($urandom));
        else write_reg(CFG_COEFF, $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom) | 16'd1);
      end
      if ($urandom_range(0, 5) == 0) write_reg(CFG_ENABLED, 16'd1);
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (2500) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("looped_motion_recorder_player_tb OK");
    end else begin
      $display("looped_motion_recorder_player_tb NOT OK");
    end
    $finish;
  end

endmodule
